>>> design/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// Types and constants shared by the FAT16 cluster table engine.
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int TABLE_ENTRIES_DEF = 16384;
  localparam int LIM_W             = 17;

  localparam logic [14:0] SCAN_LIMIT_RESET = 15'd15616;
  localparam logic [15:0] LINK_END_MIN     = 16'hFFF8;
  localparam logic [15:0] LINK_EOC         = 16'hFFFF;

  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_ALLOC = 3'd2;
  localparam logic [2:0] OP_FREE  = 3'd3;
  localparam logic [2:0] OP_COUNT = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] cluster;
    logic [15:0] value;
  } fct_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_value;
    logic [14:0] chain_count;
  } fct_out_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } fct_stat_t;

endpackage

>>> design/fct_ram.sv
// ----------------------------------------------------------------------------
// fct_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/fct_seq.sv
// ----------------------------------------------------------------------------
// fct_seq
// Operation sequencer: clearing pass, table reads and writes,
// allocate scan, chain walks and the result register.
// ----------------------------------------------------------------------------
module fct_seq
  import fct_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int AW = $clog2(TABLE_ENTRIES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LIM_W-1:0] lim_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  fct_in_t          in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fct_out_t         out_item_o,
  output fct_stat_t        stat_o,
  output logic             ram_we_o,
  output logic [AW-1:0]    ram_waddr_o,
  output logic [15:0]      ram_wdata_o,
  output logic             ram_re_o,
  output logic [AW-1:0]    ram_raddr_o,
  input  logic [15:0]      ram_rdata_i
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_WALK   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_ENTRIES - 1);

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [14:0]   n_q, n_d;
  logic          clear_q, clear_d;
  fct_out_t      res_q, res_d;
  fct_out_t      out_q, out_d;
  logic          out_valid_q, out_valid_d;
  logic          fwd_q, fwd_d;
  logic [15:0]   fwd_data_q;
  logic [15:0]   rdata;

  always_comb begin
    logic [LIM_W-1:0] cl17;
    logic [LIM_W-1:0] nxt17;
    logic [14:0]      n_inc;
    logic             cl_in;

    state_d     = state_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    n_d         = n_q;
    clear_d     = clear_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = cur_q;
    ram_wdata_o = 16'd0;
    ram_re_o    = 1'b0;
    ram_raddr_o = cur_q;
    cl17        = LIM_W'(in_item_i.cluster);
    cl_in       = cl17 < lim_i;
    nxt17       = LIM_W'(rdata);
    n_inc       = n_q + 15'd1;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        clr_d       = clr_q + AW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          clear_d = (in_item_i.opcode == OP_FREE);
          n_d     = 15'd0;
          res_d   = '{status: ST_BAD, result_value: 16'd0, chain_count: 15'd0};
          state_d = S_FINISH;
          case (in_item_i.opcode)
            OP_READ: begin
              if (cl_in) begin
                ram_re_o    = 1'b1;
                ram_raddr_o = AW'(in_item_i.cluster);
                state_d     = S_RDWAIT;
              end
            end
            OP_WRITE: begin
              if (cl_in) begin
                ram_we_o     = 1'b1;
                ram_waddr_o  = AW'(in_item_i.cluster);
                ram_wdata_o  = in_item_i.value;
                res_d.status = ST_OK;
              end
            end
            OP_ALLOC: begin
              if (lim_i > LIM_W'(2)) begin
                cur_d       = AW'(2);
                ram_re_o    = 1'b1;
                ram_raddr_o = AW'(2);
                state_d     = S_SCAN;
              end else begin
                res_d.status = ST_FULL;
              end
            end
            OP_FREE, OP_COUNT: begin
              if (cl_in && cl17 >= LIM_W'(2)) begin
                cur_d       = AW'(in_item_i.cluster);
                ram_re_o    = 1'b1;
                ram_raddr_o = AW'(in_item_i.cluster);
                state_d     = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RDWAIT: begin
        res_d.status       = ST_OK;
        res_d.result_value = rdata;
        state_d            = S_FINISH;
      end
      S_SCAN: begin
        if (rdata == 16'd0) begin
          ram_we_o           = 1'b1;
          ram_wdata_o        = LINK_EOC;
          res_d.status       = ST_OK;
          res_d.result_value = 16'(cur_q);
          state_d            = S_FINISH;
        end else if (LIM_W'(cur_q) + LIM_W'(1) >= lim_i) begin
          res_d.status = ST_FULL;
          state_d      = S_FINISH;
        end else begin
          cur_d       = cur_q + AW'(1);
          ram_re_o    = 1'b1;
          ram_raddr_o = cur_q + AW'(1);
        end
      end
      S_WALK: begin
        ram_we_o           = clear_q;
        n_d                = n_inc;
        res_d.result_value = 16'(cur_q);
        res_d.chain_count  = n_inc;
        if (rdata >= LINK_END_MIN) begin
          res_d.status = ST_OK;
          state_d      = S_FINISH;
        end else if (nxt17 < LIM_W'(2) || nxt17 >= lim_i || LIM_W'(n_inc) >= lim_i) begin
          res_d.status = ST_BAD;
          state_d      = S_FINISH;
        end else begin
          cur_d       = AW'(rdata);
          ram_re_o    = 1'b1;
          ram_raddr_o = AW'(rdata);
        end
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    fwd_d = ram_re_o && ram_we_o && (ram_raddr_o == ram_waddr_o);
  end

  // same-cycle write and read of one entry returns the new data
  assign rdata = fwd_q ? fwd_data_q : ram_rdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      fwd_q       <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    n_q        <= n_d;
    clear_q    <= clear_d;
    res_q      <= res_d;
    out_q      <= out_d;
    fwd_data_q <= ram_wdata_o;
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_q;
  assign stat_o.clearing = (state_q == S_CLEAR);
  assign stat_o.busy     = (state_q != S_IDLE) && (state_q != S_CLEAR);

endmodule

>>> design/fat16_cluster_table_engine.sv
// ----------------------------------------------------------------------------
// fat16_cluster_table_engine
// FAT16 allocation table held in on-chip RAM, one table operation per item.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in       input      valid / stall      fct_in_t  (opcode, cluster, value)
//  out      output     valid / stall      fct_out_t (status, result_value, chain_count)
//  cfg      input      valid / ready      scan_limit, 15 bits
//
//  write makes a single table write, read a single table read; allocate
//  reads each entry scanned, free and count read each link followed.
//  after reset a clearing pass over all TABLE_ENTRIES entries zeroes the table;
//  no item is taken meanwhile, configuration writes are.
//  one item is worked on at a time; a finished result waits in the output
//  register while the next item is taken, and a stalled output holds the
//  sequencer only when a second result is ready.
// ----------------------------------------------------------------------------
module fat16_cluster_table_engine
  import fct_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  fct_in_t     in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output fct_out_t    out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i
);

  localparam int AW = $clog2(TABLE_ENTRIES);

  logic [14:0]      scan_limit_q;
  logic [LIM_W-1:0] lim;
  fct_stat_t        stat;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [15:0]      ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [15:0]      ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_limit_q <= SCAN_LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      scan_limit_q <= cfg_data_i;
    end
  end

  assign lim = (LIM_W'(scan_limit_q) > LIM_W'(TABLE_ENTRIES)) ? LIM_W'(TABLE_ENTRIES)
                                                               : LIM_W'(scan_limit_q);

  fct_seq #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .lim_i      (lim),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .stat_o     (stat),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

  fct_ram #(
    .WIDTH(16),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  a_no_item_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) stat.clearing |-> in_stall_o
  ) else $error("item taken during clearing pass");

  a_busy_after_accept : assert property (
    @(posedge clk_i) disable iff (!rst_ni) (in_valid_i && !in_stall_o) |=> stat.busy
  ) else $error("sequencer not busy after item accepted");

  a_result_from_busy : assert property (
    @(posedge clk_i) disable iff (!rst_ni) $rose(out_valid_o) |-> $past(stat.busy)
  ) else $error("result appeared without an item in work");

  a_no_clear_write_collision : assert property (
    @(posedge clk_i) disable iff (!rst_ni) stat.clearing |-> !ram_re
  ) else $error("table read during clearing pass");

endmodule
